// File: src/fpp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpp_pkg
// Shared sizes and types of the feature proximity pruning block.
// ----------------------------------------------------------------------------
package fpp_pkg;

    // table and field sizes
    localparam int MAX_ENTRIES = 64;
    localparam int COORD_BITS  = 16;
    localparam int AGE_BITS    = 16;
    localparam int DIST_BITS   = 33;

    // derived widths
    localparam int CNT_BITS = $clog2(MAX_ENTRIES + 1);
    localparam int SQ_BITS  = 2 * COORD_BITS;
    localparam int SUM_BITS = SQ_BITS + 1;
    localparam int CMP_BITS = (SUM_BITS > DIST_BITS) ? SUM_BITS : DIST_BITS;

    // request travelling down the row of cells
    typedef struct packed {
        logic                  valid;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [AGE_BITS-1:0]   age;
        logic [CNT_BITS-1:0]   rem;    // stored entries still ahead
        logic                  store;  // request still has to be written
        logic                  full;   // no room left in this frame
        logic                  drop;   // some earlier feature is too close
    } t_query;

endpackage

// File: src/fpp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpp_feat_if / fpp_res_if
// Valid/ready channels for feature requests and pruning results.
// ----------------------------------------------------------------------------
interface fpp_feat_if;
    logic                          valid;
    logic                          ready;
    logic [fpp_pkg::COORD_BITS-1:0] x_pos;
    logic [fpp_pkg::COORD_BITS-1:0] y_pos;
    logic [fpp_pkg::AGE_BITS-1:0]   age;
    logic                          frame_start;

    modport source (output valid, x_pos, y_pos, age, frame_start, input ready);
    modport sink   (input valid, x_pos, y_pos, age, frame_start, output ready);
endinterface

interface fpp_res_if;
    logic valid;
    logic ready;
    logic keep;
    logic table_full;

    modport source (output valid, keep, table_full, input ready);
    modport sink   (input valid, keep, table_full, output ready);
endinterface

// File: src/fpp_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpp_cell
// One table entry: holds a stored feature, checks a passing request against
// it in two stages (squares, then sum and compare) and stores the request
// when the request reaches the first free entry.
// ----------------------------------------------------------------------------
module fpp_cell (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [fpp_pkg::DIST_BITS-1:0]  i_close_dist_sq,
    input  fpp_pkg::t_query                i_q,
    output fpp_pkg::t_query                o_q
);

    // stored entry
    logic [fpp_pkg::COORD_BITS-1:0] r_x;
    logic [fpp_pkg::COORD_BITS-1:0] r_y;
    logic [fpp_pkg::AGE_BITS-1:0]   r_age;

    // stage registers
    fpp_pkg::t_query              r_s1, n_s1;
    fpp_pkg::t_query              r_s2, n_s2;
    logic [fpp_pkg::SQ_BITS-1:0]  r_sx, n_sx;
    logic [fpp_pkg::SQ_BITS-1:0]  r_sy, n_sy;
    logic                         r_hit, n_hit;

    logic                           active;
    logic                           take;
    logic [fpp_pkg::COORD_BITS-1:0] dx;
    logic [fpp_pkg::COORD_BITS-1:0] dy;
    logic [fpp_pkg::SUM_BITS-1:0]   sum;

    // stage 1: distances, squares, age check, store decision
    always_comb begin
        active = (i_q.rem != '0);
        take   = i_q.valid && !active && i_q.store;
        dx     = (i_q.x > r_x) ? (i_q.x - r_x) : (r_x - i_q.x);
        dy     = (i_q.y > r_y) ? (i_q.y - r_y) : (r_y - i_q.y);
        n_sx   = fpp_pkg::SQ_BITS'(dx) * fpp_pkg::SQ_BITS'(dx);
        n_sy   = fpp_pkg::SQ_BITS'(dy) * fpp_pkg::SQ_BITS'(dy);
        n_hit  = active && (r_age >= i_q.age);
        n_s1   = i_q;
        n_s1.rem = active ? (i_q.rem - fpp_pkg::CNT_BITS'(1)) : '0;
        if (take) begin
            n_s1.store = 1'b0;
        end
    end

    // stage 2: sum of squares against the threshold
    always_comb begin
        sum  = fpp_pkg::SUM_BITS'(r_sx) + fpp_pkg::SUM_BITS'(r_sy);
        n_s2 = r_s1;
        n_s2.drop = r_s1.drop ||
                    (r_hit && (fpp_pkg::CMP_BITS'(sum) <
                               fpp_pkg::CMP_BITS'(i_close_dist_sq)));
    end

    // write the entry when the request lands here
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_x   <= i_q.x;
            r_y   <= i_q.y;
            r_age <= i_q.age;
        end
    end

    // advance the request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
            r_s2.valid <= 1'b0;
        end else begin
            r_s1 <= n_s1;
            r_s2 <= n_s2;
        end
    end

    // hold the squares for stage 2
    always_ff @(posedge i_clk) begin
        r_sx  <= n_sx;
        r_sy  <= n_sy;
        r_hit <= n_hit;
    end

    assign o_q = r_s2;

endmodule

// File: src/feature_proximity_pruning.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// feature_proximity_pruning
// Radius non-maximum suppression of tracked features over a row of cells.
// ----------------------------------------------------------------------------
//  channel   dir  handshake     payload
//  i_feat    in   valid/ready   x_pos, y_pos, age, frame_start
//  o_res     out  valid/ready   keep, table_full
//  i_cfg_*   in   write enable  close_dist_sq (33 bits)
//
//  One feature at a time: a request walks the row of MAX_ENTRIES cells, two
//  register stages per cell, then the holding register; the next feature can
//  be taken once the result has moved on from the holding register into the
//  output register.
//  Reset is synchronous and empties the table and the threshold.
//  A stalled result waits in the output register while the next request runs;
//  a second finished result waits in a holding register and holds the input
//  off until the output register frees up.
// ----------------------------------------------------------------------------
module feature_proximity_pruning (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [fpp_pkg::DIST_BITS-1:0] i_cfg_data,
    fpp_feat_if.sink                      i_feat,
    fpp_res_if.source                     o_res
);

    logic [fpp_pkg::DIST_BITS-1:0] r_close_dist_sq;
    logic [fpp_pkg::CNT_BITS-1:0]  r_count, n_count;
    logic [fpp_pkg::CNT_BITS-1:0]  eff_count;
    logic                          r_busy;
    logic                          r_res_valid;
    logic                          r_res_keep;
    logic                          r_res_full;
    logic                          r_out_valid;
    logic                          r_out_keep;
    logic                          r_out_full;
    logic                          accept;
    logic                          is_full;
    logic                          move_out;

    fpp_pkg::t_query w_link [fpp_pkg::MAX_ENTRIES+1];

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_close_dist_sq <= '0;
        end else if (i_cfg_we) begin
            r_close_dist_sq <= i_cfg_data;
        end
    end

    // build the request entering the row
    always_comb begin
        accept    = i_feat.valid && !r_busy;
        eff_count = i_feat.frame_start ? '0 : r_count;
        is_full   = (eff_count >= fpp_pkg::CNT_BITS'(fpp_pkg::MAX_ENTRIES));
        n_count   = is_full ? eff_count : (eff_count + fpp_pkg::CNT_BITS'(1));
        w_link[0].valid = accept;
        w_link[0].x     = i_feat.x_pos;
        w_link[0].y     = i_feat.y_pos;
        w_link[0].age   = i_feat.age;
        w_link[0].rem   = eff_count;
        w_link[0].store = !is_full;
        w_link[0].full  = is_full;
        w_link[0].drop  = 1'b0;
    end

    assign i_feat.ready = !r_busy;

    // row of cells
    for (genvar g = 0; g < fpp_pkg::MAX_ENTRIES; g++) begin : g_cell
        fpp_cell u_cell (
            .i_clk           (i_clk),
            .i_rst_n         (i_rst_n),
            .i_close_dist_sq (r_close_dist_sq),
            .i_q             (w_link[g]),
            .o_q             (w_link[g+1])
        );
    end

    // entry count and busy flag
    assign move_out = r_res_valid && (!r_out_valid || o_res.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_busy  <= 1'b0;
        end else begin
            if (accept) begin
                r_count <= n_count;
                r_busy  <= 1'b1;
            end else if (move_out) begin
                r_busy  <= 1'b0;
            end
        end
    end

    // hold the finished result, then hand it to the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_link[fpp_pkg::MAX_ENTRIES].valid) begin
                r_res_valid <= 1'b1;
            end else if (move_out) begin
                r_res_valid <= 1'b0;
            end
            if (move_out) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_link[fpp_pkg::MAX_ENTRIES].valid) begin
            r_res_keep <= !w_link[fpp_pkg::MAX_ENTRIES].drop;
            r_res_full <= w_link[fpp_pkg::MAX_ENTRIES].full;
        end
        if (move_out) begin
            r_out_keep <= r_res_keep;
            r_out_full <= r_res_full;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.keep       = r_out_keep;
    assign o_res.table_full = r_out_full;

`ifndef ASSERT_OFF
    // a result leaves the row only while a request is in flight
    a_end_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_link[fpp_pkg::MAX_ENTRIES].valid |-> r_busy)
        else $error("row produced a result with no request in flight");

    // the holding register is empty whenever a new request is taken
    a_res_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> !r_res_valid)
        else $error("request accepted while a result is still held");

    // the table never counts more entries than it has
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= fpp_pkg::CNT_BITS'(fpp_pkg::MAX_ENTRIES))
        else $error("entry count above table size");

    // a frame start leaves exactly one stored entry
    a_frame_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_feat.frame_start) |=> (r_count == fpp_pkg::CNT_BITS'(1)))
        else $error("frame start did not restart the table");

    // a full table result always carries a count at the table size
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && w_link[0].full) |=>
            (r_count == fpp_pkg::CNT_BITS'(fpp_pkg::MAX_ENTRIES)))
        else $error("table reported full below its size");
`endif

endmodule

// File: verif/feature_proximity_pruning_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// feature_proximity_pruning_tb
// Self-checking bench for the radius suppression block. A scoreboard keeps
// its own feature table and threshold, and works out keep / table_full for
// every accepted request. Directed frames cover disabled pruning, the
// coordinate and age extremes, equal ages and table overflow. Random frames
// follow, under changing thresholds and idle patterns on both channels.
// ----------------------------------------------------------------------------
module feature_proximity_pruning_tb;

    localparam int HALF_PERIOD    = 2;
    localparam int RESULT_LATENCY = 2 * fpp_pkg::MAX_ENTRIES + 2;
    localparam int CYCLE_LIMIT    = 1_200_000;
    localparam logic [fpp_pkg::COORD_BITS-1:0] COORD_TOP = '1;
    localparam logic [fpp_pkg::AGE_BITS-1:0]   AGE_TOP   = '1;
    localparam int PHASE_ITEMS    = 130;
    localparam logic [fpp_pkg::DIST_BITS-1:0] DIST_MAX = '1;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    typedef struct packed {
        logic [fpp_pkg::COORD_BITS-1:0] x;
        logic [fpp_pkg::COORD_BITS-1:0] y;
        logic [fpp_pkg::AGE_BITS-1:0]   age;
        logic                           frame_start;
    } t_feature;

    typedef struct packed {
        logic keep;
        logic table_full;
    } t_verdict;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          i_cfg_we;
    logic [fpp_pkg::DIST_BITS-1:0] i_cfg_data;

    fpp_feat_if feat_bus ();
    fpp_res_if  res_bus ();

    feature_proximity_pruning DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_feat     (feat_bus),
        .o_res      (res_bus)
    );

    // scoreboard copy of the threshold and of the current frame's table
    logic [fpp_pkg::DIST_BITS-1:0]  prune_dist_sq = '0;
    logic [fpp_pkg::COORD_BITS-1:0] seen_x [fpp_pkg::MAX_ENTRIES];
    logic [fpp_pkg::COORD_BITS-1:0] seen_y [fpp_pkg::MAX_ENTRIES];
    logic [fpp_pkg::AGE_BITS-1:0]   seen_age [fpp_pkg::MAX_ENTRIES];
    int                             seen_count = 0;

    t_verdict   pending_verdicts [$];
    t_idle_mode idle_mode       = IDLE_NONE;
    int         hold_off_cycles = 0;
    int         fail_count      = 0;
    int         cycle_count     = 0;

    // clock
    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    // watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("%0t: timeout after %0d cycles", $time, CYCLE_LIMIT);
        $display("feature_proximity_pruning verification failed");
        $finish;
    end

    // judge one feature against the earlier ones of its frame, then store it
    function automatic t_verdict judge_feature(input t_feature f);
        t_verdict    v;
        logic [63:0] dx;
        logic [63:0] dy;
        logic [63:0] dsq;
        if (f.frame_start) begin
            seen_count = 0;
        end
        v.keep = 1'b1;
        if (prune_dist_sq != '0) begin
            for (int i = 0; i < seen_count; i++) begin
                if (seen_age[i] >= f.age) begin
                    dx  = 64'((f.x > seen_x[i]) ? f.x - seen_x[i] : seen_x[i] - f.x);
                    dy  = 64'((f.y > seen_y[i]) ? f.y - seen_y[i] : seen_y[i] - f.y);
                    dsq = dx * dx + dy * dy;
                    if (dsq < {31'b0, prune_dist_sq}) begin
                        v.keep = 1'b0;
                        break;
                    end
                end
            end
        end
        v.table_full = (seen_count >= fpp_pkg::MAX_ENTRIES);
        if (!v.table_full) begin
            seen_x[seen_count]   = f.x;
            seen_y[seen_count]   = f.y;
            seen_age[seen_count] = f.age;
            seen_count++;
        end
        return v;
    endfunction

    // random coordinate around a center, clamped to the field range
    function automatic logic [fpp_pkg::COORD_BITS-1:0] near(input int center,
                                                            input int spread);
        int v;
        v = center + int'($urandom_range(2 * spread)) - spread;
        if (v < 0) begin
            v = 0;
        end
        if (v > int'(COORD_TOP)) begin
            v = int'(COORD_TOP);
        end
        return v[fpp_pkg::COORD_BITS-1:0];
    endfunction

    // offer one request, idling first as the mode asks; valid stays high after
    task automatic send_feature(input logic [fpp_pkg::COORD_BITS-1:0] x,
                                input logic [fpp_pkg::COORD_BITS-1:0] y,
                                input logic [fpp_pkg::AGE_BITS-1:0]   age,
                                input logic                           start);
        t_feature f;
        int       gap_pct;
        gap_pct = (idle_mode == IDLE_SENDER) ? 86 : (idle_mode == IDLE_BOTH) ? 6 : 0;
        while (int'($urandom_range(99)) < gap_pct) begin
            feat_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        f.x                  = x;
        f.y                  = y;
        f.age                = age;
        f.frame_start        = start;
        feat_bus.valid       <= 1'b1;
        feat_bus.x_pos       <= x;
        feat_bus.y_pos       <= y;
        feat_bus.age         <= age;
        feat_bus.frame_start <= start;
        do @(posedge i_clk); while (!feat_bus.ready);
        pending_verdicts.push_back(judge_feature(f));
    endtask

    // drop valid and hold until every expected result has come back
    task automatic wait_for_results();
        feat_bus.valid <= 1'b0;
        do @(posedge i_clk); while (pending_verdicts.size() != 0);
    endtask

    // write the threshold once the block is idle
    task automatic write_dist_threshold(input logic [fpp_pkg::DIST_BITS-1:0] value);
        wait_for_results();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we      <= 1'b0;
        prune_dist_sq = value;
    endtask

    // one frame of features clustered around a random center; a broken frame
    // may lack its opening frame_start or carry extra ones
    task automatic send_frame(input int len, input int spread, input bit broken);
        int                           cx;
        int                           cy;
        logic                         start;
        logic [fpp_pkg::AGE_BITS-1:0] age;
        cx = int'($urandom_range(COORD_TOP));
        cy = int'($urandom_range(COORD_TOP));
        for (int i = 0; i < len; i++) begin
            if (i == 0) begin
                start = broken ? logic'($urandom_range(1)) : 1'b1;
            end else begin
                start = broken && ($urandom_range(15) == 0);
            end
            age = ($urandom_range(4) == 0) ? fpp_pkg::AGE_BITS'($urandom_range(AGE_TOP))
                                           : fpp_pkg::AGE_BITS'($urandom_range(15));
            send_feature(near(cx, spread), near(cy, spread), age, start);
        end
    endtask

    function automatic int pick_spread();
        case ($urandom_range(3))
            0: return 4;
            1: return 48;
            2: return 600;
            default: return 30000;
        endcase
    endfunction

    // checker: compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_verdict want;
        if (i_rst_n && res_bus.valid && res_bus.ready) begin
            if (pending_verdicts.size() == 0) begin
                $display("%0t: unexpected result keep=%0b table_full=%0b",
                         $time, res_bus.keep, res_bus.table_full);
                fail_count++;
            end else begin
                want = pending_verdicts.pop_front();
                if (res_bus.keep !== want.keep) begin
                    $display("%0t: keep mismatch, expected %0b, actual %0b",
                             $time, want.keep, res_bus.keep);
                    fail_count++;
                end
                if (res_bus.table_full !== want.table_full) begin
                    $display("%0t: table_full mismatch, expected %0b, actual %0b",
                             $time, want.table_full, res_bus.table_full);
                    fail_count++;
                end
            end
        end
    end

    // receiver: stall at random per mode, or hold off for a counted stretch
    initial begin
        int stall_pct;
        res_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            stall_pct = (idle_mode == IDLE_RECEIVER) ? 86 :
                        (idle_mode == IDLE_BOTH)     ? 6  : 0;
            if (hold_off_cycles > 0) begin
                hold_off_cycles--;
                res_bus.ready <= 1'b0;
            end else begin
                res_bus.ready <= (int'($urandom_range(99)) >= stall_pct);
            end
        end
    end

    // zero threshold: identical features all survive
    task automatic test_pruning_disabled();
        idle_mode = IDLE_NONE;
        write_dist_threshold('0);
        send_feature(16'd500, 16'd500, 16'd3, 1'b1);
        send_feature(16'd500, 16'd500, 16'd3, 1'b0);
        send_feature(16'd500, 16'd500, AGE_TOP, 1'b0);
        send_feature(16'd500, 16'd500, 16'd0, 1'b0);
    endtask

    // extremes of position and age, equal ages, strict distance compare
    task automatic test_age_and_distance();
        write_dist_threshold(DIST_MAX);
        send_feature(16'd0, 16'd0, 16'd0, 1'b1);
        send_feature(COORD_TOP, COORD_TOP, 16'd0, 1'b0);
        send_feature(COORD_TOP, COORD_TOP, AGE_TOP, 1'b0);
        send_feature(16'd0, 16'd0, AGE_TOP, 1'b0);
        send_feature(16'd0, COORD_TOP, AGE_TOP, 1'b0);
        write_dist_threshold(33'd1);
        send_feature(16'd100, 16'd100, 16'd5, 1'b1);
        send_feature(16'd100, 16'd100, 16'd5, 1'b0);
        send_feature(16'd100, 16'd101, 16'd5, 1'b0);
        send_feature(16'd100, 16'd100, 16'd6, 1'b0);
        send_feature(16'd100, 16'd100, 16'd4, 1'b0);
        send_feature(16'd100, 16'd100, 16'd0, 1'b1);
    endtask

    // frames longer than the table, then a fresh frame to clear the count
    task automatic test_table_full();
        write_dist_threshold(33'd4096);
        send_frame(70, 200, 1'b0);
        send_frame(66, 4, 1'b0);
        send_frame(3, 48, 1'b0);
    endtask

    // random frames across thresholds and idle patterns
    task automatic test_random_traffic();
        logic [fpp_pkg::DIST_BITS-1:0] phase_dist;
        int                            sent;
        int                            len;
        for (int phase = 0; phase < 12; phase++) begin
            case (phase % 6)
                0: phase_dist = '0;
                1: phase_dist = 33'd4096;
                2: phase_dist = 33'd1 << 20;
                3: begin
                    phase_dist[31:0] = $urandom();
                    phase_dist[32]   = 1'($urandom_range(1));
                end
                4: phase_dist = DIST_MAX;
                default: phase_dist = fpp_pkg::DIST_BITS'($urandom_range(1 << 16));
            endcase
            write_dist_threshold(phase_dist);
            idle_mode = t_idle_mode'(phase % 4);
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                len = ($urandom_range(11) == 0) ? $urandom_range(60, 72) : $urandom_range(1, 24);
                send_frame(len, pick_spread(), $urandom_range(7) == 0);
                sent += len;
            end
        end
        idle_mode = IDLE_NONE;
    endtask

    // long receiver hold-off while requests keep coming, then drain
    task automatic test_backpressure();
        write_dist_threshold(33'd1 << 14);
        idle_mode       = IDLE_NONE;
        hold_off_cycles = 900;
        send_frame(12, 48, 1'b0);
        wait_for_results();
    endtask

    initial begin
        i_rst_n              <= 1'b0;
        i_cfg_we             <= 1'b0;
        i_cfg_data           <= '0;
        feat_bus.valid       <= 1'b0;
        feat_bus.x_pos       <= '0;
        feat_bus.y_pos       <= '0;
        feat_bus.age         <= '0;
        feat_bus.frame_start <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_pruning_disabled();
        test_age_and_distance();
        test_table_full();
        test_random_traffic();
        test_backpressure();

        // let any stray result show up before the verdict
        wait_for_results();
        repeat (RESULT_LATENCY + 20) @(posedge i_clk);
        if (pending_verdicts.size() != 0) begin
            $display("%0t: %0d expected results never arrived",
                     $time, pending_verdicts.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("feature_proximity_pruning verification clean");
        end else begin
            $display("feature_proximity_pruning verification failed");
        end
        $finish;
    end

endmodule
